// File: hw/rtl/ftct_pkg.sv
// ----------------------------------------------------------------------------
// ftct_pkg
// Types and constants shared by the flow tuple cuckoo table.
// ----------------------------------------------------------------------------
package ftct_pkg;

  localparam int unsigned Slots    = 1024;
  localparam int unsigned Ways     = 4;
  localparam int unsigned SlotW    = $clog2(Slots);
  localparam int unsigned WayW     = $clog2(Ways);
  localparam int unsigned EntryW   = 1 + WayW + SlotW;
  localparam int unsigned Entries  = 2 * Ways * Slots;

  // operation codes; the spare code acts as a search
  localparam logic [1:0] KindInsert = 2'd0;
  localparam logic [1:0] KindDelete = 2'd1;
  localparam logic [1:0] KindSearch = 2'd2;
  localparam logic [1:0] KindSpare  = 2'd3;

  // result status codes
  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StUpdated  = 3'd1;
  localparam logic [2:0] StFound    = 3'd2;
  localparam logic [2:0] StNotFound = 3'd3;
  localparam logic [2:0] StDeleted  = 3'd4;
  localparam logic [2:0] StFailed   = 3'd5;
  localparam logic [2:0] StDelMiss  = 3'd6;

  localparam logic [6:0] KicksReset = 7'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        is_tcp;
    logic [1:0]  start_way;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] flow_count;
    logic [1:0]  hit_way;
    logic [9:0]  hit_slot;
  } rsp_t;

  // one table entry as stored
  typedef struct packed {
    logic [63:0] addr;
    logic [31:0] ports;
    logic [31:0] count;
  } entry_t;

  // slot of a tuple in a given way
  function automatic logic [SlotW-1:0] slot_of(logic [63:0] addr, logic [31:0] ports,
                                               logic [WayW-1:0] way);
    logic [31:0] h;
    logic [31:0] m;
    logic [31:0] p;
    h = addr[63:32] ^ addr[31:0] ^ {16'd0, ports[31:16]} ^ {16'd0, ports[15:0]};
    unique case (way)
      2'd0:    m = 32'd13;
      2'd1:    m = 32'd17;
      2'd2:    m = 32'd19;
      default: m = 32'd23;
    endcase
    p = h * m;
    return p[SlotW-1:0];
  endfunction

endpackage

// File: hw/rtl/flow_tuple_cuckoo_table_core.sv
// ----------------------------------------------------------------------------
// flow_tuple_cuckoo_table_core
// Four-way cuckoo flow table with TCP and UDP halves in one entry memory.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  request   start_i, busy_o, req_i           in
//  result    done_o, rsp_o                    out (one cycle strobe)
//  config    psel/penable/pwrite/paddr/pwdata in, prdata/pready out
//
// Each way is read in turn, through an issue state and a compare state; each
// eviction step likewise passes through a read and a compare state. Reset
// starts a clearing pass over all Entries (8192) valid bits with busy held
// high. No stall from the receiver; a result shows for one cycle.
module flow_tuple_cuckoo_table_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  ftct_pkg::req_t      req_i,
  output logic                done_o,
  output ftct_pkg::rsp_t      rsp_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned EW = ftct_pkg::EntryW;
  localparam int unsigned SW = ftct_pkg::SlotW;
  localparam int unsigned WW = ftct_pkg::WayW;

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SLkRd  = 3'd2;
  localparam logic [2:0] SLkCmp = 3'd3;
  localparam logic [2:0] SInRd  = 3'd4;
  localparam logic [2:0] SInCmp = 3'd5;
  localparam logic [2:0] SDone  = 3'd6;

  // config register
  logic [6:0] kicks_max_q;
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {25'd0, kicks_max_q} : 32'd0;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kicks_max_q <= ftct_pkg::KicksReset;
    end else if (psel && penable && pwrite && paddr == 2'd0) begin
      kicks_max_q <= pwdata[6:0];
    end
  end

  // memories: valid bits and entry payload
  logic                  vmem [ftct_pkg::Entries];
  ftct_pkg::entry_t      emem [ftct_pkg::Entries];
  logic                  v_we, e_we, v_wd;
  logic [EW-1:0]         v_wa, e_wa, rd_a;
  ftct_pkg::entry_t      e_wd, e_rd;
  logic                  v_rd;

  always_ff @(posedge clk_i) begin
    if (v_we) vmem[v_wa] <= v_wd;
    if (e_we) emem[e_wa] <= e_wd;
    v_rd <= vmem[rd_a];
    e_rd <= emem[rd_a];
  end

  // control state
  logic [2:0]        st_q, st_d;
  ftct_pkg::req_t    rq_q, rq_d;
  logic [WW-1:0]     way_q, way_d;
  logic [EW-1:0]     clr_q, clr_d;
  logic [63:0]       ca_q, ca_d;
  logic [31:0]       cp_q, cp_d, cc_q, cc_d;
  logic              cnew_q, cnew_d, placed_q, placed_d;
  logic [WW-1:0]     nway_q, nway_d;
  logic [SW-1:0]     nslot_q, nslot_d;
  logic [6:0]        kicks_q, kicks_d;
  ftct_pkg::rsp_t    rsp_q, rsp_d;
  logic              done_q, done_d;

  logic [63:0]       rq_addr;
  logic [31:0]       rq_ports;
  logic [SW-1:0]     lk_slot, in_slot;
  logic              hit;

  assign rq_addr  = {rq_q.src_addr, rq_q.dst_addr};
  assign rq_ports = {rq_q.src_port, rq_q.dst_port};
  assign lk_slot  = ftct_pkg::slot_of(rq_addr, rq_ports, way_q);
  assign in_slot  = ftct_pkg::slot_of(ca_q, cp_q, way_q);
  assign hit      = v_rd && e_rd.addr == rq_addr && e_rd.ports == rq_ports;

  always_comb begin
    st_d = st_q; rq_d = rq_q; way_d = way_q; clr_d = clr_q;
    ca_d = ca_q; cp_d = cp_q; cc_d = cc_q; cnew_d = cnew_q; placed_d = placed_q;
    nway_d = nway_q; nslot_d = nslot_q; kicks_d = kicks_q;
    rsp_d = rsp_q; done_d = 1'b0;
    v_we = 1'b0; v_wa = clr_q; v_wd = 1'b0;
    e_we = 1'b0; e_wa = '0; e_wd = '0;
    rd_a = '0;
    unique case (st_q)
      SClear: begin
        v_we = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == EW'(ftct_pkg::Entries - 1)) st_d = SIdle;
      end
      SIdle: begin
        if (start_i) begin
          rq_d = req_i; way_d = '0; st_d = SLkRd;
        end
      end
      SLkRd: begin
        rd_a = {rq_q.is_tcp, way_q, lk_slot};
        st_d = SLkCmp;
      end
      SLkCmp: begin
        if (hit) begin
          rsp_d.hit_way = way_q; rsp_d.hit_slot = 10'(lk_slot);
          if (rq_q.kind == ftct_pkg::KindInsert) begin
            e_we = 1'b1; e_wa = {rq_q.is_tcp, way_q, lk_slot};
            e_wd = e_rd;
            if (e_rd.count != 32'hFFFF_FFFF) e_wd.count = e_rd.count + 32'd1;
            rsp_d.status = ftct_pkg::StUpdated; rsp_d.flow_count = e_wd.count;
          end else if (rq_q.kind == ftct_pkg::KindDelete) begin
            v_we = 1'b1; v_wa = {rq_q.is_tcp, way_q, lk_slot}; v_wd = 1'b0;
            rsp_d.status = ftct_pkg::StDeleted; rsp_d.flow_count = '0;
          end else begin
            rsp_d.status = ftct_pkg::StFound; rsp_d.flow_count = e_rd.count;
          end
          st_d = SDone;
        end else if (way_q != WW'(ftct_pkg::Ways - 1)) begin
          way_d = way_q + 1'b1; st_d = SLkRd;
        end else begin
          rsp_d = '0;
          if (rq_q.kind == ftct_pkg::KindInsert) begin
            ca_d = rq_addr; cp_d = rq_ports; cc_d = 32'd1;
            cnew_d = 1'b1; placed_d = 1'b0; nway_d = '0; nslot_d = '0;
            kicks_d = '0; way_d = rq_q.start_way; st_d = SInRd;
          end else begin
            rsp_d.status = (rq_q.kind == ftct_pkg::KindDelete) ?
                           ftct_pkg::StDelMiss : ftct_pkg::StNotFound;
            st_d = SDone;
          end
        end
      end
      SInRd: begin
        rd_a = {rq_q.is_tcp, way_q, in_slot};
        st_d = SInCmp;
      end
      SInCmp: begin
        if (!v_rd) begin
          // free slot: settle the carried flow here
          v_we = 1'b1; v_wa = {rq_q.is_tcp, way_q, in_slot}; v_wd = 1'b1;
          e_we = 1'b1; e_wa = v_wa; e_wd = '{addr: ca_q, ports: cp_q, count: cc_q};
          rsp_d.status = ftct_pkg::StInserted;
          if (cnew_q) begin
            rsp_d.flow_count = 32'd1; rsp_d.hit_way = way_q; rsp_d.hit_slot = 10'(in_slot);
          end else begin
            rsp_d.flow_count = placed_q ? 32'd1 : 32'd0;
            rsp_d.hit_way = nway_q; rsp_d.hit_slot = 10'(nslot_q);
          end
          st_d = SDone;
        end else if (kicks_q >= kicks_max_q) begin
          rsp_d.status = ftct_pkg::StFailed;
          if (placed_q && !cnew_q) begin
            rsp_d.flow_count = 32'd1; rsp_d.hit_way = nway_q;
            rsp_d.hit_slot = 10'(nslot_q);
          end
          st_d = SDone;
        end else begin
          // swap the carried flow with the occupant
          e_we = 1'b1; e_wa = {rq_q.is_tcp, way_q, in_slot};
          e_wd = '{addr: ca_q, ports: cp_q, count: cc_q};
          ca_d = e_rd.addr; cp_d = e_rd.ports; cc_d = e_rd.count;
          cnew_d = placed_q && nway_q == way_q && nslot_q == in_slot;
          if (cnew_q) begin
            placed_d = 1'b1; nway_d = way_q; nslot_d = in_slot;
          end else if (cnew_d) begin
            placed_d = 1'b0;
          end
          kicks_d = kicks_q + 7'd1;
          way_d = way_q + 1'b1;
          st_d = SInRd;
        end
      end
      SDone: begin
        done_d = 1'b1; st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SClear; clr_q <= '0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; clr_q <= clr_d; done_q <= done_d;
    end
  end

  // payload and chain registers
  always_ff @(posedge clk_i) begin
    rq_q <= rq_d; way_q <= way_d; ca_q <= ca_d; cp_q <= cp_d; cc_q <= cc_d;
    cnew_q <= cnew_d; placed_q <= placed_d; nway_q <= nway_d; nslot_q <= nslot_d;
    kicks_q <= kicks_d; rsp_q <= rsp_d;
  end

  assign busy_o = (st_q != SIdle);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

// File: bench/flow_tuple_cuckoo_table_core_tb.sv
// ----------------------------------------------------------------------------
// flow_tuple_cuckoo_table_core_tb
// Self-checking bench for the four-way cuckoo flow table. A clocked driver
// feeds requests from a queue and a clocked monitor checks every result beat
// against an in-bench table model. Most flows come from a pool whose hashes
// share ten low bits per class, so slots collide and eviction chains run long.
// ----------------------------------------------------------------------------
module flow_tuple_cuckoo_table_core_tb;

  localparam int unsigned WatchLimit = 20000;
  localparam int unsigned PoolSize   = 40;

  logic            clk_i   = 1'b0;
  logic            rst_ni  = 1'b0;
  logic            start_q = 1'b0;
  ftct_pkg::req_t  req_q   = '0;
  logic            busy_o;
  logic            done_o;
  ftct_pkg::rsp_t  rsp_o;
  logic            psel    = 1'b0;
  logic            penable = 1'b0;
  logic            pwrite  = 1'b0;
  logic [1:0]      paddr   = '0;
  logic [31:0]     pwdata  = '0;
  logic [31:0]     prdata;
  logic            pready;

  // table model state
  bit          tbl_valid [ftct_pkg::Entries];
  logic [63:0] tbl_addr  [ftct_pkg::Entries];
  logic [31:0] tbl_ports [ftct_pkg::Entries];
  logic [31:0] tbl_count [ftct_pkg::Entries];
  logic [6:0]  kick_limit = ftct_pkg::KicksReset;

  ftct_pkg::req_t pending_reqs [$];
  ftct_pkg::rsp_t expected_rsps [$];
  int unsigned req_sent, rsp_seen, mismatches, idle_cycles, gap_left, gap_draw;
  int unsigned fail_seen, evict_seen;
  ftct_pkg::req_t flow_pool [PoolSize];

  flow_tuple_cuckoo_table_core u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_q),
    .busy_o  (busy_o),
    .req_i   (req_q),
    .done_o  (done_o),
    .rsp_o   (rsp_o),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // slot of a tuple in one way: low bits of the wrapped product
  function automatic logic [9:0] tuple_slot(logic [63:0] a, logic [31:0] p, int unsigned w);
    logic [31:0] h;
    logic [31:0] prod;
    logic [31:0] mult [4];
    mult = '{32'd13, 32'd17, 32'd19, 32'd23};
    h = a[63:32] ^ a[31:0] ^ {16'd0, p[31:16]} ^ {16'd0, p[15:0]};
    prod = h * mult[w];
    return prod[9:0];
  endfunction

  // apply one request to the table model, return the result it yields
  function automatic ftct_pkg::rsp_t table_apply(ftct_pkg::req_t r);
    logic [63:0] a, ca, va;
    logic [31:0] pt, cp, vp, cc, vc;
    int unsigned t, w, e, sl, kicks, nw, ns;
    bit cnew, placed, vnew;
    ftct_pkg::rsp_t o;
    a = {r.src_addr, r.dst_addr};
    pt = {r.src_port, r.dst_port};
    t = r.is_tcp;
    o = '0;
    for (w = 0; w < ftct_pkg::Ways; w++) begin
      sl = tuple_slot(a, pt, w);
      e = (t * ftct_pkg::Ways + w) * ftct_pkg::Slots + sl;
      if (tbl_valid[e] && tbl_addr[e] == a && tbl_ports[e] == pt) begin
        o.hit_way = 2'(w);
        o.hit_slot = 10'(sl);
        if (r.kind == ftct_pkg::KindInsert) begin
          if (tbl_count[e] != 32'hFFFF_FFFF) tbl_count[e]++;
          o.status = ftct_pkg::StUpdated;
          o.flow_count = tbl_count[e];
        end else if (r.kind == ftct_pkg::KindDelete) begin
          tbl_valid[e] = 1'b0;
          o.status = ftct_pkg::StDeleted;
        end else begin
          o.status = ftct_pkg::StFound;
          o.flow_count = tbl_count[e];
        end
        return o;
      end
    end
    if (r.kind == ftct_pkg::KindDelete) begin
      o.status = ftct_pkg::StDelMiss;
      return o;
    end
    if (r.kind != ftct_pkg::KindInsert) begin
      o.status = ftct_pkg::StNotFound;
      return o;
    end
    // cuckoo placement with eviction chain
    ca = a; cp = pt; cc = 32'd1; cnew = 1'b1; placed = 1'b0;
    nw = 0; ns = 0; kicks = 0; w = r.start_way % ftct_pkg::Ways;
    forever begin
      sl = tuple_slot(ca, cp, w);
      e = (t * ftct_pkg::Ways + w) * ftct_pkg::Slots + sl;
      if (!tbl_valid[e]) begin
        tbl_valid[e] = 1'b1;
        tbl_addr[e] = ca;
        tbl_ports[e] = cp;
        tbl_count[e] = cc;
        if (cnew) begin
          placed = 1'b1; nw = w; ns = sl;
        end
        o.status = ftct_pkg::StInserted;
        o.flow_count = placed ? 32'd1 : 32'd0;
        o.hit_way = 2'(nw);
        o.hit_slot = 10'(ns);
        return o;
      end
      if (kicks >= kick_limit) begin
        if (cnew) placed = 1'b0;
        o.status = ftct_pkg::StFailed;
        if (placed) begin
          o.flow_count = 32'd1;
          o.hit_way = 2'(nw);
          o.hit_slot = 10'(ns);
        end
        return o;
      end
      va = tbl_addr[e]; vp = tbl_ports[e]; vc = tbl_count[e];
      vnew = placed && nw == w && ns == sl;
      tbl_addr[e] = ca; tbl_ports[e] = cp; tbl_count[e] = cc;
      if (cnew) begin
        placed = 1'b1; nw = w; ns = sl;
      end
      if (vnew) placed = 1'b0;
      ca = va; cp = vp; cc = vc; cnew = vnew;
      kicks++;
      w = (w + 1) % ftct_pkg::Ways;
    end
  endfunction

  // driver: one request beat per accept, random gaps with back-to-back stretches
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start_q && !busy_o) begin
        expected_rsps.push_back(table_apply(req_q));
        req_sent++;
        gap_draw = ((req_sent / 50) % 3 == 0) ? 0 : $urandom_range(0, 8);
        if (gap_draw == 0 && pending_reqs.size() > 0) begin
          req_q <= pending_reqs.pop_front();
        end else begin
          start_q <= 1'b0;
          gap_left <= gap_draw;
        end
      end else if (!start_q) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_reqs.size() > 0) begin
          start_q <= 1'b1;
          req_q <= pending_reqs.pop_front();
        end
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      rsp_seen++;
      if (rsp_o.status == ftct_pkg::StFailed) fail_seen++;
      if (expected_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: %p", rsp_o);
      end else begin
        ftct_pkg::rsp_t exp_rsp;
        exp_rsp = expected_rsps.pop_front();
        if (rsp_o.status !== exp_rsp.status || rsp_o.flow_count !== exp_rsp.flow_count ||
            rsp_o.hit_way !== exp_rsp.hit_way || rsp_o.hit_slot !== exp_rsp.hit_slot) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp st=%0d cnt=%0d way=%0d slot=%0d,",
                      " got st=%0d cnt=%0d way=%0d slot=%0d"},
                     exp_rsp.status, exp_rsp.flow_count, exp_rsp.hit_way, exp_rsp.hit_slot,
                     rsp_o.status, rsp_o.flow_count, rsp_o.hit_way, rsp_o.hit_slot);
        end
      end
    end
  end

  // watchdog: cycles with neither a request nor a result accepted
  always @(posedge clk_i) begin
    if ((start_q && !busy_o) || done_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic set_kick_limit(logic [6:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= '0; pwdata <= {25'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    kick_limit = v;
  endtask

  task automatic drain;
    while (pending_reqs.size() > 0 || start_q || expected_rsps.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic push_req(logic [1:0] k, ftct_pkg::req_t f, logic tcp, logic [1:0] sw);
    f.kind = k;
    f.is_tcp = tcp;
    f.start_way = sw;
    pending_reqs.push_back(f);
  endtask

  // flow whose hash low bits equal cls, so flows of one class share a slot in every way
  function automatic ftct_pkg::req_t make_flow(logic [9:0] cls);
    ftct_pkg::req_t f;
    logic [31:0] x;
    f = '0;
    f.src_addr = $urandom;
    f.dst_addr = $urandom;
    f.src_port = 16'($urandom_range(0, 65535));
    x = f.src_addr ^ f.dst_addr ^ {16'd0, f.src_port};
    f.dst_port = {6'($urandom_range(0, 63)), x[9:0] ^ cls};
    return f;
  endfunction

  task automatic random_phase(int unsigned n);
    ftct_pkg::req_t f;
    int unsigned pick;
    repeat (n) begin
      if ($urandom_range(0, 99) < 85) f = flow_pool[$urandom_range(0, PoolSize - 1)];
      else f = make_flow(10'($urandom));
      pick = $urandom_range(0, 99);
      push_req(pick < 50 ? ftct_pkg::KindInsert : pick < 70 ? ftct_pkg::KindDelete :
               pick < 95 ? ftct_pkg::KindSearch : ftct_pkg::KindSpare,
               f, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
    end
    drain();
  endtask

  initial begin
    ftct_pkg::req_t f;
    logic [6:0] limits [6];
    for (int i = 0; i < PoolSize; i++) flow_pool[i] = make_flow(10'(i % 6) * 10'd97);
    limits = '{7'd1, 7'd64, 7'd0, 7'd127, 7'($urandom_range(1, 64)), 7'($urandom_range(2, 8))};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    set_kick_limit(ftct_pkg::KicksReset);

    // directed: each operation, miss cases, unused kind, field extremes
    f = flow_pool[0];
    push_req(ftct_pkg::KindInsert, f, 1'b1, 2'd0);
    push_req(ftct_pkg::KindInsert, f, 1'b1, 2'd3);
    push_req(ftct_pkg::KindSearch, f, 1'b1, 2'd0);
    push_req(ftct_pkg::KindSpare, f, 1'b1, 2'd0);
    push_req(ftct_pkg::KindSearch, f, 1'b0, 2'd0);
    push_req(ftct_pkg::KindDelete, f, 1'b1, 2'd1);
    push_req(ftct_pkg::KindDelete, f, 1'b1, 2'd1);
    push_req(ftct_pkg::KindSearch, f, 1'b1, 2'd2);
    f = '0;
    push_req(ftct_pkg::KindInsert, f, 1'b0, 2'd3);
    push_req(ftct_pkg::KindSearch, f, 1'b0, 2'd0);
    f = '1;
    push_req(ftct_pkg::KindInsert, f, 1'b1, 2'd2);
    push_req(ftct_pkg::KindInsert, f, 1'b1, 2'd2);
    push_req(ftct_pkg::KindDelete, f, 1'b1, 2'd0);
    // six flows sharing one slot in every way: chain runs out
    for (int i = 0; i < 6; i++) begin
      push_req(ftct_pkg::KindInsert, flow_pool[6 * i + 1], 1'b0, 2'(i));
    end
    for (int i = 0; i < 6; i++) begin
      push_req(ftct_pkg::KindSearch, flow_pool[6 * i + 1], 1'b0, 2'd0);
    end
    drain();

    // random phases across kick limits, the extremes included
    for (int p = 0; p < 6; p++) begin
      set_kick_limit(limits[p]);
      random_phase(105);
    end

    repeat (300) @(posedge clk_i);
    $display("ran %0d requests and %0d results over six kick limits (0 to 127),", req_sent,
             rsp_seen);
    $display("including %0d failed inserts; %0d mismatches", fail_seen, mismatches);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
